// ===== hw/rtl/keyframe_position_sampler_defines.svh =====
// Assertion macros shared by the sampler RTL
`ifndef KEYFRAME_POSITION_SAMPLER_DEFINES_SVH
`define KEYFRAME_POSITION_SAMPLER_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define KPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define KPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/kps_pkg.sv =====
package kps_pkg;

    // Product and quotient width of the shared multiply / divide path
    localparam int PROD_W    = 50;
    localparam int DIV_STEPS = 50;
    localparam int CNT_W     = 6;

    localparam logic [15:0] DEN_8BIT  = 16'd255;
    localparam logic [15:0] DEN_16BIT = 16'd65535;

    // Configuration register indexes
    localparam logic [2:0] REG_NUM_KEYS   = 3'd0;
    localparam logic [2:0] REG_TRACK_MODE = 3'd1;
    localparam logic [2:0] REG_MIN_X      = 3'd2;
    localparam logic [2:0] REG_MIN_Y      = 3'd3;
    localparam logic [2:0] REG_MIN_Z      = 3'd4;
    localparam logic [2:0] REG_RANGE_X    = 3'd5;
    localparam logic [2:0] REG_RANGE_Y    = 3'd6;
    localparam logic [2:0] REG_RANGE_Z    = 3'd7;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] num;
        logic [15:0]              den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] quot;
    } div_resp_t;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W:0] v);
        logic signed [31:0] r;
        if (v > $signed({{(PROD_W-31){1'b0}}, 32'h7FFF_FFFF}))
            r = 32'sh7FFF_FFFF;
        else if (v < $signed({{(PROD_W-31){1'b1}}, 32'h8000_0000}))
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/kps_key_store.sv =====
module kps_key_store #(
    parameter int MAX_KEYS = 256,
    parameter int KW       = $clog2(MAX_KEYS)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [KW-1:0] wr_addr,
    input  logic [7:0]    wr_frame,
    input  logic [47:0]   wr_scaler,
    input  logic [KW-1:0] rd_addr,
    output logic [7:0]    rd_frame,
    output logic [47:0]   rd_scaler
);

    logic [7:0]  frame_mem [MAX_KEYS];
    logic [47:0] scaler_mem [MAX_KEYS];

    // Write one key, read one key per cycle with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr]  <= wr_frame;
            scaler_mem[wr_addr] <= wr_scaler;
        end
        rd_frame  <= frame_mem[rd_addr];
        rd_scaler <= scaler_mem[rd_addr];
    end

endmodule

// ===== hw/rtl/kps_divider.sv =====
module kps_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  kps_pkg::div_req_t  req,
    output kps_pkg::div_resp_t resp
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic                         neg_reg, neg_next;
    logic                         fold_reg, fold_next;
    logic                         wide_reg, wide_next;
    logic [kps_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [15:0]                  den_reg, den_next;
    logic [15:0]                  rem_reg, rem_next;
    logic [kps_pkg::PROD_W-1:0]   dvd_reg, dvd_next;
    logic [kps_pkg::PROD_W-1:0]   acc_reg, acc_next;
    logic [kps_pkg::PROD_W-1:0]   mag;
    logic [16:0]                  trial;
    logic                         ge;
    logic [kps_pkg::PROD_W-1:0]   fold_hi;
    logic [kps_pkg::PROD_W-1:0]   fold_lo;
    logic [kps_pkg::PROD_W-1:0]   fold_inc;

    // Magnitude plus half the divisor gives round-half-away on the quotient
    assign mag   = (req.num[kps_pkg::PROD_W-1] ? kps_pkg::PROD_W'(-req.num)
                                               : kps_pkg::PROD_W'(req.num))
                   + kps_pkg::PROD_W'(req.den >> 1);
    assign trial = {rem_reg, dvd_reg[kps_pkg::PROD_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    // Divisor 2^k - 1: split off the high part, add it to the quotient and fold it back
    assign fold_hi  = wide_reg ? (dvd_reg >> 16) : (dvd_reg >> 8);
    assign fold_lo  = wide_reg ? {{(kps_pkg::PROD_W-16){1'b0}}, dvd_reg[15:0]}
                               : {{(kps_pkg::PROD_W-8){1'b0}}, dvd_reg[7:0]};
    assign fold_inc = {{(kps_pkg::PROD_W-1){1'b0}},
                       (fold_lo == {{(kps_pkg::PROD_W-16){1'b0}}, den_reg})};

    // Fold path for 255 and 65535, otherwise one quotient bit per cycle, restoring form
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        fold_next = fold_reg;
        wide_next = wide_reg;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.num[kps_pkg::PROD_W-1];
            fold_next = (req.den == kps_pkg::DEN_8BIT) || (req.den == kps_pkg::DEN_16BIT);
            wide_next = (req.den == kps_pkg::DEN_16BIT);
            cnt_next  = '0;
            den_next  = req.den;
            rem_next  = '0;
            dvd_next  = mag;
            acc_next  = '0;
        end
        else if (busy_reg && fold_reg)
        begin
            if (fold_hi != '0)
            begin
                acc_next = acc_reg + fold_hi;
                dvd_next = fold_hi + fold_lo;
            end
            else
            begin
                dvd_next  = acc_reg + fold_inc;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            dvd_next = {dvd_reg[kps_pkg::PROD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == kps_pkg::CNT_W'(kps_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        fold_reg <= fold_next;
        wide_reg <= wide_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        acc_reg  <= acc_next;
    end

    assign resp.done = done_reg;
    assign resp.quot = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);

endmodule

// ===== hw/rtl/keyframe_position_sampler.sv =====
// Channel   Direction  Handshake              Payload
// s_axis    in         tvalid / tready        tuser command, tdata key load or frame
// m_axis    out        tvalid / tready        tuser updated, tdata pos_x, pos_y, pos_z
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// A load, an empty track or a one-key track goes straight to the output. A sample
// searches the keys one at a time unless the track is indexed by frame, decodes
// each key it uses through divides by 255 or 65535 on the fold path, and for a
// blend runs three divides by the key span.
// Reset clears control state only; the key memory holds its contents. A stalled
// result holds in the output register, and the next item waits in its final
// state until that register is free.
module keyframe_position_sampler #(
    parameter int MAX_KEYS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] key_index, [15:8] key_frame, [31:16] scale_x, [47:32] scale_y,
    // [63:48] scale_z, [79:64] frame
    input  logic [79:0] s_axis_tdata,
    // [0] command
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
    output logic [95:0] m_axis_tdata,
    // [0] updated
    output logic [0:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    `include "keyframe_position_sampler_defines.svh"

    localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_KRD  = 4'd3;
    localparam logic [3:0] S_KLAT = 4'd4;
    localparam logic [3:0] S_KMUL = 4'd5;
    localparam logic [3:0] S_KGO  = 4'd6;
    localparam logic [3:0] S_KDIV = 4'd7;
    localparam logic [3:0] S_BMUL = 4'd8;
    localparam logic [3:0] S_BGO  = 4'd9;
    localparam logic [3:0] S_BDIV = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    // Configuration registers
    logic [8:0]         num_keys_reg;
    logic [1:0]         track_mode_reg;
    logic signed [31:0] min_reg [3];
    logic signed [31:0] range_reg [3];

    // Sequencer state
    logic [3:0]    state_reg, state_next;
    logic [15:0]   frame_reg, frame_next;
    logic [8:0]    i_reg, i_next;
    logic [8:0]    n_reg, n_next;
    logic [7:0]    prev_reg, prev_next;
    logic [7:0]    off_reg, off_next;
    logic [7:0]    span_reg, span_next;
    logic [KW-1:0] key_idx_reg, key_idx_next;
    logic          second_reg, second_next;
    logic          blend_reg, blend_next;
    logic          ok_reg, ok_next;
    logic [1:0]    axis_reg, axis_next;
    logic [47:0]   sc_reg, sc_next;
    logic signed [kps_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [31:0] p_reg [3];
    logic signed [31:0] p_next [3];
    logic signed [31:0] q_reg [3];
    logic signed [31:0] q_next [3];
    logic          out_valid_reg, out_valid_next;
    logic          out_upd_reg, out_upd_next;
    logic [95:0]   out_data_reg, out_data_next;

    // Input fields
    logic          in_cmd;
    logic [7:0]    in_key_index;
    logic [7:0]    in_key_frame;
    logic [47:0]   in_scalers;
    logic [15:0]   in_frame;
    logic [8:0]    n_calc;

    // Key store and shared units
    logic          wr_en;
    logic [KW-1:0] rd_addr;
    logic [7:0]    rd_frame;
    logic [47:0]   rd_scaler;
    logic [15:0]   axis_scale;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [kps_pkg::PROD_W-1:0] mul_prod;
    logic signed [31:0] sum_base;
    logic signed [31:0] sum_sat;
    kps_pkg::div_req_t  div_req;
    kps_pkg::div_resp_t div_resp;

    assign in_cmd       = s_axis_tuser[0];
    assign in_key_index = s_axis_tdata[7:0];
    assign in_key_frame = s_axis_tdata[15:8];
    assign in_scalers   = s_axis_tdata[63:16];
    assign in_frame     = s_axis_tdata[79:64];

    assign n_calc = ({8'd0, num_keys_reg} > 17'(MAX_KEYS)) ? 9'(MAX_KEYS) : num_keys_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_upd_reg;
    assign m_axis_tdata  = out_data_reg;

    // Key store: write on an accepted load within range
    assign wr_en   = s_axis_tvalid && s_axis_tready && (in_cmd == kps_pkg::CMD_LOAD)
                     && ({9'd0, in_key_index} < 17'(MAX_KEYS));
    assign rd_addr = (state_reg == S_SRD) ? KW'(i_reg) : key_idx_reg;

    kps_key_store #(
        .MAX_KEYS (MAX_KEYS),
        .KW       (KW)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (KW'(in_key_index)),
        .wr_frame  (in_key_frame),
        .wr_scaler (in_scalers),
        .rd_addr   (rd_addr),
        .rd_frame  (rd_frame),
        .rd_scaler (rd_scaler)
    );

    // Shared multiplier: scaler decode or blend difference times offset
    assign axis_scale = track_mode_reg[1] ? sc_reg[axis_reg*16 +: 16]
                                          : {8'd0, sc_reg[axis_reg*16 +: 8]};
    always_comb
    begin
        if (state_reg == S_BMUL)
        begin
            mul_a = {q_reg[axis_reg][31], q_reg[axis_reg]}
                    - {p_reg[axis_reg][31], p_reg[axis_reg]};
            mul_b = {9'd0, off_reg};
        end
        else
        begin
            mul_a = {range_reg[axis_reg][31], range_reg[axis_reg]};
            mul_b = {1'b0, axis_scale};
        end
    end
    assign mul_prod = mul_a * mul_b;

    // Shared divider request
    assign div_req.start = (state_reg == S_KGO) || (state_reg == S_BGO);
    assign div_req.num   = prod_reg;
    assign div_req.den   = (state_reg == S_BGO) ? {8'd0, span_reg}
                         : (track_mode_reg[1] ? kps_pkg::DEN_16BIT : kps_pkg::DEN_8BIT);

    kps_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // Add quotient to the minimum or to the first key, then clamp
    assign sum_base = (state_reg == S_BDIV) ? p_reg[axis_reg] : min_reg[axis_reg];
    assign sum_sat  = kps_pkg::sat32({{(kps_pkg::PROD_W-31){sum_base[31]}}, sum_base}
                                     + {div_resp.quot[kps_pkg::PROD_W-1], div_resp.quot});

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        frame_next     = frame_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        prev_next      = prev_reg;
        off_next       = off_reg;
        span_next      = span_reg;
        key_idx_next   = key_idx_reg;
        second_next    = second_reg;
        blend_next     = blend_reg;
        ok_next        = ok_reg;
        axis_next      = axis_reg;
        sc_next        = sc_reg;
        prod_next      = prod_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_upd_next   = out_upd_reg;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    frame_next  = in_frame;
                    n_next      = n_calc;
                    i_next      = '0;
                    second_next = 1'b0;
                    blend_next  = 1'b0;
                    ok_next     = 1'b0;
                    if (in_cmd == kps_pkg::CMD_LOAD || n_calc == 9'd0)
                        state_next = S_FIN;
                    else if (n_calc == 9'd1)
                    begin
                        p_next     = min_reg;
                        ok_next    = 1'b1;
                        state_next = S_FIN;
                    end
                    else if (track_mode_reg[0])
                    begin
                        key_idx_next = ({1'b0, in_frame} < {8'd0, n_calc})
                                       ? KW'(in_frame) : KW'(n_calc - 9'd1);
                        ok_next      = 1'b1;
                        state_next   = S_KRD;
                    end
                    else
                        state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                if (i_reg == n_reg)
                begin
                    key_idx_next = KW'(n_reg - 9'd1);
                    ok_next      = 1'b1;
                    state_next   = S_KRD;
                end
                else
                    state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if ({8'd0, rd_frame} < frame_reg)
                begin
                    prev_next  = rd_frame;
                    i_next     = i_reg + 9'd1;
                    state_next = S_SRD;
                end
                else if ({8'd0, rd_frame} == frame_reg)
                begin
                    key_idx_next = KW'(i_reg);
                    ok_next      = 1'b1;
                    state_next   = S_KRD;
                end
                else if (i_reg == 9'd0)
                    state_next = S_FIN;
                else
                begin
                    key_idx_next = KW'(i_reg - 9'd1);
                    blend_next   = 1'b1;
                    off_next     = 8'(frame_reg - {8'd0, prev_reg});
                    span_next    = rd_frame - prev_reg;
                    ok_next      = 1'b1;
                    state_next   = S_KRD;
                end
            end
            S_KRD:
                state_next = S_KLAT;
            S_KLAT:
            begin
                sc_next    = rd_scaler;
                axis_next  = '0;
                state_next = S_KMUL;
            end
            S_KMUL:
            begin
                prod_next  = mul_prod;
                state_next = S_KGO;
            end
            S_KGO:
                state_next = S_KDIV;
            S_KDIV:
            begin
                if (div_resp.done)
                begin
                    if (second_reg)
                        q_next[axis_reg] = sum_sat;
                    else
                        p_next[axis_reg] = sum_sat;
                    if (axis_reg != 2'd2)
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_KMUL;
                    end
                    else if (blend_reg && !second_reg)
                    begin
                        second_next  = 1'b1;
                        key_idx_next = KW'(i_reg);
                        state_next   = S_KRD;
                    end
                    else if (blend_reg)
                    begin
                        axis_next  = '0;
                        state_next = S_BMUL;
                    end
                    else
                        state_next = S_FIN;
                end
            end
            S_BMUL:
            begin
                prod_next  = mul_prod;
                state_next = S_BGO;
            end
            S_BGO:
                state_next = S_BDIV;
            S_BDIV:
            begin
                if (div_resp.done)
                begin
                    p_next[axis_reg] = sum_sat;
                    if (axis_reg == 2'd2)
                        state_next = S_FIN;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_BMUL;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_upd_next   = ok_reg;
                    out_data_next  = ok_reg ? {p_reg[2], p_reg[1], p_reg[0]} : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            num_keys_reg   <= '0;
            track_mode_reg <= '0;
            min_reg        <= '{default: '0};
            range_reg      <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    kps_pkg::REG_NUM_KEYS:   num_keys_reg   <= cfg_data[8:0];
                    kps_pkg::REG_TRACK_MODE: track_mode_reg <= cfg_data[1:0];
                    kps_pkg::REG_MIN_X:      min_reg[0]     <= cfg_data;
                    kps_pkg::REG_MIN_Y:      min_reg[1]     <= cfg_data;
                    kps_pkg::REG_MIN_Z:      min_reg[2]     <= cfg_data;
                    kps_pkg::REG_RANGE_X:    range_reg[0]   <= cfg_data;
                    kps_pkg::REG_RANGE_Y:    range_reg[1]   <= cfg_data;
                    kps_pkg::REG_RANGE_Z:    range_reg[2]   <= cfg_data;
                    default:                 num_keys_reg   <= num_keys_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        frame_reg    <= frame_next;
        i_reg        <= i_next;
        n_reg        <= n_next;
        prev_reg     <= prev_next;
        off_reg      <= off_next;
        span_reg     <= span_next;
        key_idx_reg  <= key_idx_next;
        second_reg   <= second_next;
        blend_reg    <= blend_next;
        ok_reg       <= ok_next;
        axis_reg     <= axis_next;
        sc_reg       <= sc_next;
        prod_reg     <= prod_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        out_upd_reg  <= out_upd_next;
        out_data_reg <= out_data_next;
    end

    `KPS_ASSERT(a_fin_holds_on_stall,
        (state_reg == S_FIN && out_valid_reg && !m_axis_tready) |=> (state_reg == S_FIN),
        "finished item left while the output register was still full")
    `KPS_ASSERT(a_no_data_is_zero,
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0),
        "result without a position carries nonzero data")
    `KPS_ASSERT_ALWAYS(a_div_done_expected,
        div_resp.done |-> (state_reg == S_KDIV || state_reg == S_BDIV || !rst_n),
        "divider finished while the sequencer was not waiting for it")

endmodule
